>>> rtl/core/yrc_pkg.sv
// Shared widths, register codes and fixed-point helpers for the YUV to RGB combiner.
package yrc_pkg;

  localparam int BYTE_W    = 8;
  localparam int CH_N      = 3;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int Q_FRAC    = 16;
  localparam int QU_W      = Q_FRAC + 1;   // unsigned 0..1.0
  localparam int Q_W       = Q_FRAC + 2;   // signed -1.0..1.0
  localparam int PROD_W    = 2 * Q_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS   = 2'd0,
    REG_USCALE = 2'd1,
    REG_VSCALE = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] BIAS_RST   = 24'h14C700;
  localparam logic [CFG_W-1:0] USCALE_RST = 24'h083CFA;
  localparam logic [CFG_W-1:0] VSCALE_RST = 24'hCC6980;

  localparam logic [QU_W-1:0] Q_ONE_U = 17'd65536;

  // round(n * 65536 / 255) = n * 257 + round(n / 255)
  function automatic logic [QU_W-1:0] byte_to_q(input logic [BYTE_W-1:0] n);
    return {1'b0, n, n} + {{(QU_W-1){1'b0}}, n[BYTE_W-1]};
  endfunction

  // Channel 0 is red in the top byte, channel 2 blue in the bottom byte.
  function automatic logic [BYTE_W-1:0] reg_byte(input logic [CFG_W-1:0] r, input int ch);
    return r[BYTE_W*(CH_N-1-ch) +: BYTE_W];
  endfunction

endpackage

>>> rtl/core/yrc_ifs.sv
// Handshake channel interfaces: pixel input, pixel output and register write.
interface yrc_pix_in_if import yrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] y_red;
  logic [BYTE_W-1:0] y_green;
  logic [BYTE_W-1:0] y_blue;
  logic [BYTE_W-1:0] u_red;
  logic [BYTE_W-1:0] u_green;
  logic [BYTE_W-1:0] u_blue;
  logic [BYTE_W-1:0] v_red;
  logic [BYTE_W-1:0] v_green;
  logic [BYTE_W-1:0] v_blue;

  modport source (output valid, y_red, y_green, y_blue, u_red, u_green, u_blue,
                  v_red, v_green, v_blue, input ready);
  modport sink   (input valid, y_red, y_green, y_blue, u_red, u_green, u_blue,
                  v_red, v_green, v_blue, output ready);
endinterface

interface yrc_pix_out_if import yrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface yrc_cfg_if import yrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/yuv_rgb_combiner_pixel.sv
// YUV to RGB register-combiner pixel: four-stage pipeline, one pixel per clock while out_pix is not stalled.
//
//   channel   direction  payload
//   in_pix    sink       Y, U, V texel bytes for red, green, blue
//   out_pix   source     out_red, out_green, out_blue
//   cfg_wr    sink       register index, 24-bit packed RGB data
//
// One request per clock in and out while out_pix is not stalled; an accepted
// input passes through the registers of the stages decode, multiply, combine
// and scale, in that order, before it reaches out_pix.
// Synchronous active-low reset clears the valid bits and restores the registers.
// A stall on out_pix holds each full stage with no empty stage after it; empty stages keep filling.
// Register writes are always accepted.
module yuv_rgb_combiner_pixel import yrc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  yrc_pix_in_if.sink    in_pix,
  yrc_pix_out_if.source out_pix,
  yrc_cfg_if.sink       cfg_wr
);

  localparam logic signed [Q_W+1:0] S0_ONE  = 20'sd65536;
  localparam logic signed [Q_W+1:0] S0_NONE = -20'sd65536;
  localparam logic signed [Q_W:0]   S1_ONE  = 19'sd65536;
  localparam logic signed [Q_W:0]   S1_NONE = -19'sd65536;
  localparam logic signed [Q_W:0]   S_HALF  = 19'sd32768;

  // Configuration registers
  logic [CFG_W-1:0] bias_r, uscale_r, vscale_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= BIAS_RST;
      uscale_r <= USCALE_RST;
      vscale_r <= VSCALE_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_BIAS:   bias_r   <= cfg_wr.data;
        REG_USCALE: uscale_r <= cfg_wr.data;
        REG_VSCALE: vscale_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Stage flow control
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy;

  assign d_rdy        = !d_vld_r || out_pix.ready;
  assign c_rdy        = !c_vld_r || d_rdy;
  assign b_rdy        = !b_vld_r || c_rdy;
  assign a_rdy        = !a_vld_r || b_rdy;
  assign in_pix.ready = a_rdy;
  assign out_pix.valid = d_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_pix.valid;
      if (b_rdy) b_vld_r <= a_vld_r;
      if (c_rdy) c_vld_r <= b_vld_r;
      if (d_rdy) d_vld_r <= c_vld_r;
    end
  end

  // Stage A: decode bytes, first combiner, signed U and V terms
  logic [BYTE_W-1:0] y_b [CH_N];
  logic [BYTE_W-1:0] u_b [CH_N];
  logic [BYTE_W-1:0] v_b [CH_N];

  assign y_b[0] = in_pix.y_red;
  assign y_b[1] = in_pix.y_green;
  assign y_b[2] = in_pix.y_blue;
  assign u_b[0] = in_pix.u_red;
  assign u_b[1] = in_pix.u_green;
  assign u_b[2] = in_pix.u_blue;
  assign v_b[0] = in_pix.v_red;
  assign v_b[1] = in_pix.v_green;
  assign v_b[2] = in_pix.v_blue;

  logic signed [Q_W-1:0] a_s0_nxt [CH_N];
  logic signed [Q_W-1:0] a_d1_nxt [CH_N];
  logic signed [Q_W-1:0] a_d2_nxt [CH_N];
  logic [QU_W-1:0]       a_us_nxt [CH_N];
  logic [QU_W-1:0]       a_vs_nxt [CH_N];

  always_comb begin
    logic [QU_W-1:0]         t0, t1, t2, bq;
    logic signed [Q_W+1:0]   s0_sum, s0_half;
    logic [Q_W:0]            dd1, dd2;
    for (int ch = 0; ch < CH_N; ch++) begin
      t0 = byte_to_q(y_b[ch]);
      t1 = byte_to_q(u_b[ch]);
      t2 = byte_to_q(v_b[ch]);
      bq = byte_to_q(reg_byte(bias_r, ch));
      a_us_nxt[ch] = byte_to_q(reg_byte(uscale_r, ch));
      a_vs_nxt[ch] = byte_to_q(reg_byte(vscale_r, ch));

      s0_sum  = $signed({3'b000, t0}) + $signed({2'b00, bq, 1'b0}) - S0_ONE;
      s0_half = s0_sum >>> 1;
      if (s0_half > S0_ONE) begin
        a_s0_nxt[ch] = S0_ONE[Q_W-1:0];
      end else if (s0_half < S0_NONE) begin
        a_s0_nxt[ch] = S0_NONE[Q_W-1:0];
      end else begin
        a_s0_nxt[ch] = s0_half[Q_W-1:0];
      end

      // 2t - 1.0 always fits the signed Q width
      dd1 = {1'b0, t1, 1'b0} - {2'b00, Q_ONE_U};
      dd2 = {1'b0, t2, 1'b0} - {2'b00, Q_ONE_U};
      a_d1_nxt[ch] = dd1[Q_W-1:0];
      a_d2_nxt[ch] = dd2[Q_W-1:0];
    end
  end

  logic signed [Q_W-1:0] a_s0_r [CH_N];
  logic signed [Q_W-1:0] a_d1_r [CH_N];
  logic signed [Q_W-1:0] a_d2_r [CH_N];
  logic [QU_W-1:0]       a_us_r [CH_N];
  logic [QU_W-1:0]       a_vs_r [CH_N];

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_s0_r <= a_s0_nxt;
      a_d1_r <= a_d1_nxt;
      a_d2_r <= a_d2_nxt;
      a_us_r <= a_us_nxt;
      a_vs_r <= a_vs_nxt;
    end
  end

  // Stage B: scale products
  logic signed [Q_W-1:0]    b_s0_r [CH_N];
  logic signed [PROD_W-1:0] b_p1_r [CH_N];
  logic signed [PROD_W-1:0] b_p2_r [CH_N];
  logic signed [PROD_W-1:0] b_p1_nxt [CH_N];
  logic signed [PROD_W-1:0] b_p2_nxt [CH_N];

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      b_p1_nxt[ch] = a_d1_r[ch] * $signed({1'b0, a_us_r[ch]});
      b_p2_nxt[ch] = a_d2_r[ch] * $signed({1'b0, a_vs_r[ch]});
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_s0_r <= a_s0_r;
      b_p1_r <= b_p1_nxt;
      b_p2_r <= b_p2_nxt;
    end
  end

  // Stage C: drop product fraction, second combiner, final sum and clamp
  logic [QU_W-1:0] c_s_nxt [CH_N];
  logic [QU_W-1:0] c_s_r   [CH_N];

  always_comb begin
    logic signed [Q_W-1:0] m1, m2, s1;
    logic signed [Q_W:0]   s1_sum, sum;
    for (int ch = 0; ch < CH_N; ch++) begin
      // upper bits of the product are the floored Q16 value
      m1 = $signed(b_p1_r[ch][Q_FRAC +: Q_W]);
      m2 = $signed(b_p2_r[ch][Q_FRAC +: Q_W]);
      s1_sum = m1 + m2;
      if (s1_sum > S1_ONE) begin
        s1 = S1_ONE[Q_W-1:0];
      end else if (s1_sum < S1_NONE) begin
        s1 = S1_NONE[Q_W-1:0];
      end else begin
        s1 = s1_sum[Q_W-1:0];
      end
      sum = b_s0_r[ch] + s1;
      // clamp 2*sum to 0..1.0
      if (sum <= 0) begin
        c_s_nxt[ch] = '0;
      end else if (sum >= S_HALF) begin
        c_s_nxt[ch] = Q_ONE_U;
      end else begin
        c_s_nxt[ch] = {sum[Q_FRAC-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) c_s_r <= c_s_nxt;
  end

  // Stage D: scale to byte into the output register
  logic [BYTE_W-1:0] d_byte_nxt [CH_N];
  logic [BYTE_W-1:0] d_byte_r   [CH_N];

  always_comb begin
    logic [QU_W+BYTE_W-1:0] prod;
    for (int ch = 0; ch < CH_N; ch++) begin
      prod = {c_s_r[ch], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, c_s_r[ch]};
      d_byte_nxt[ch] = prod[Q_FRAC +: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy) d_byte_r <= d_byte_nxt;
  end

  assign out_pix.out_red   = d_byte_r[0];
  assign out_pix.out_green = d_byte_r[1];
  assign out_pix.out_blue  = d_byte_r[2];

endmodule
